FILE: rtl/core/evad_pkg.sv
package evad_pkg;

  localparam int SUM_W      = 48;
  localparam int FRAME_W    = 16;
  localparam int RMS_W      = 23;
  localparam int CNT_W      = 4;
  localparam int FLEN_W     = 11;
  localparam int GAP_W      = 10;
  localparam int PAD_W      = 6;
  localparam int DLY_W      = 7;
  localparam int FIR_W      = 53;
  localparam int FILTER_TAPS      = 5;
  localparam int HIST_DEPTH       = FILTER_TAPS - 1;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int MAX_FRAME_DEF    = 1024;
  localparam int ARG_W      = 46;
  localparam int ADDR_W     = 5;

  localparam logic [2:0] REG_FRAME_LENGTH = 3'd0;
  localparam logic [2:0] REG_LOW_THR      = 3'd1;
  localparam logic [2:0] REG_HIGH_THR     = 3'd2;
  localparam logic [2:0] REG_MAX_SOUNDS   = 3'd3;
  localparam logic [2:0] REG_MAX_GAP      = 3'd4;
  localparam logic [2:0] REG_PAD          = 3'd5;
  localparam logic [2:0] REG_RIGHT_EN     = 3'd6;

  typedef struct packed {
    logic [FLEN_W-1:0] frame_length;
    logic [RMS_W-1:0]  low_threshold;
    logic [RMS_W-1:0]  high_threshold;
    logic [CNT_W-1:0]  max_sounds;
    logic [GAP_W-1:0]  max_gap_frames;
    logic [PAD_W-1:0]  pad_frames;
    logic              right_enable;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]   left_sum;
    logic [SUM_W-1:0]   right_sum;
    logic [FRAME_W-1:0] frame;
  } frame_rec_t;

  typedef struct packed {
    logic [RMS_W-1:0]   left_rms;
    logic [RMS_W-1:0]   right_rms;
    logic [FRAME_W-1:0] phrase_length;
    logic [CNT_W-1:0]   sound_count;
  } result_t;

  function automatic logic [DLY_W-1:0] post_pad(input logic [PAD_W-1:0] pad);
    logic [DLY_W-1:0] v;
    v = (pad > PAD_W'(4)) ? DLY_W'(pad - PAD_W'(3)) : DLY_W'(1);
    return v;
  endfunction

  function automatic logic [FRAME_W-1:0] plen(input logic [FRAME_W-1:0] last,
                                             input logic [FRAME_W-1:0] first);
    logic [FRAME_W-1:0] n;
    n = last - first + FRAME_W'(1);
    return (n == '0) ? '1 : n;
  endfunction

endpackage

FILE: rtl/core/evad_fifo.sv
module evad_fifo import evad_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end
endmodule

FILE: rtl/core/evad_front.sv
module evad_front import evad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          frame_end,
  input  logic [FRAME_W-1:0]            frame_number,
  input  logic                          right_enable,
  output logic                          rec_push,
  output frame_rec_t                    rec
);
  localparam int SQ_W = 2 * SAMPLE_BITS;

  logic [SUM_W-1:0]       lsum_r, rsum_r, lsum_nxt, rsum_nxt;
  logic [SAMPLE_BITS-1:0] lmag, rmag;
  logic [SQ_W-1:0]        lsq, rsq;
  logic [SUM_W:0]         lacc, racc;

  assign lmag = left_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-left_sample)  : left_sample;
  assign rmag = right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-right_sample) : right_sample;
  assign lsq  = lmag * lmag;
  assign rsq  = rmag * rmag;
  assign lacc = {1'b0, lsum_r} + (SUM_W + 1)'(lsq);
  assign racc = {1'b0, rsum_r} + (SUM_W + 1)'(rsq);

  always_comb begin
    lsum_nxt = lacc[SUM_W] ? '1 : lacc[SUM_W-1:0];
    rsum_nxt = rsum_r;
    if (right_enable) begin
      rsum_nxt = racc[SUM_W] ? '1 : racc[SUM_W-1:0];
    end
  end

  assign rec_push      = accept && frame_end;
  assign rec.left_sum  = lsum_nxt;
  assign rec.right_sum = rsum_nxt;
  assign rec.frame     = frame_number;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsum_r <= '0;
      rsum_r <= '0;
    end else if (accept) begin
      lsum_r <= frame_end ? '0 : lsum_nxt;
      rsum_r <= frame_end ? '0 : rsum_nxt;
    end
  end
endmodule

FILE: rtl/core/evad_back.sv
module evad_back import evad_pkg::*; #(
  parameter int MAX_FRAME_LENGTH = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       rec_empty,
  input  frame_rec_t rec,
  output logic       rec_pop,
  input  logic       res_full,
  output logic       res_push,
  output result_t    res
);
  localparam int LW    = $clog2(MAX_FRAME_LENGTH + 1) + 1;
  localparam int DW    = $clog2(17 * MAX_FRAME_LENGTH + 1);
  localparam int DVD_W = FIR_W + 16;
  localparam int DCW   = $clog2(DVD_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FIR1 = 3'd1;
  localparam logic [2:0] S_FIR2 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_SM   = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0]         st_r;
  logic               ch_r;
  frame_rec_t         rec_r;
  logic [SUM_W-1:0]   lh_r [HIST_DEPTH];
  logic [SUM_W-1:0]   rh_r [HIST_DEPTH];
  logic [FIR_W-1:0]   acc_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DW-1:0]      rem_r;
  logic [ARG_W-1:0]   q_r, sx_r;
  logic               ovf_r;
  logic [DCW-1:0]     cnt_r;
  logic [ARG_W:0]     sres_r, sbit_r;
  logic [RMS_W-1:0]   lrms_r, rrms_r;

  logic [CNT_W-1:0]   snd_r, snd_nxt;
  logic [FRAME_W-1:0] pff_r, pff_nxt, plf_r, plf_nxt, lse_r, lse_nxt, rl_r, rl_nxt;
  logic               ins_r, ins_nxt, inp_r, inp_nxt, ppa_r, ppa_nxt;
  logic [RMS_W-1:0]   prev_r, prev_nxt;
  logic [DLY_W-1:0]   pre_r, pre_nxt, post_r, post_nxt;
  logic               hclr;

  logic [LW-1:0]      len;
  logic [DW-1:0]      dval;
  logic [SUM_W-1:0]   x;
  logic [SUM_W-1:0]   h0, h1, h2, h3;
  logic [FIR_W-1:0]   fsum;
  logic [DW:0]        rs;
  logic               ge;
  logic [ARG_W+1:0]   st_sum;
  logic [FRAME_W-1:0] diff;
  logic [DLY_W-1:0]   pps;

  always_comb begin
    if (cfg.frame_length == '0) begin
      len = LW'(1);
    end else if (LW'(cfg.frame_length) > LW'(MAX_FRAME_LENGTH)) begin
      len = LW'(MAX_FRAME_LENGTH);
    end else begin
      len = LW'(cfg.frame_length);
    end
  end
  assign dval = DW'((DW + 5)'(len) * (DW + 5)'(17));

  assign x  = ch_r ? rec_r.right_sum : rec_r.left_sum;
  assign h0 = ch_r ? rh_r[0] : lh_r[0];
  assign h1 = ch_r ? rh_r[1] : lh_r[1];
  assign h2 = ch_r ? rh_r[2] : lh_r[2];
  assign h3 = ch_r ? rh_r[3] : lh_r[3];
  assign fsum = acc_r + FIR_W'(h1) + (FIR_W'(h2) << 2) + (FIR_W'(h3) << 1);

  assign rs     = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rs >= (DW + 1)'(dval);
  assign st_sum = {1'b0, sres_r} + {1'b0, sbit_r};

  assign rec_pop  = (st_r == S_IDLE) && !rec_empty;
  assign res_push = (st_r == S_PUSH) && !res_full;
  assign res.left_rms      = lrms_r;
  assign res.right_rms     = rrms_r;
  assign res.phrase_length = rl_r;
  assign res.sound_count   = snd_r;

  always_comb begin
    snd_nxt  = snd_r;
    pff_nxt  = pff_r;
    plf_nxt  = plf_r;
    lse_nxt  = lse_r;
    ins_nxt  = ins_r;
    inp_nxt  = inp_r;
    ppa_nxt  = ppa_r;
    rl_nxt   = rl_r;
    prev_nxt = prev_r;
    pre_nxt  = pre_r;
    post_nxt = post_r;
    hclr     = 1'b0;
    diff     = '0;
    pps      = post_pad(cfg.pad_frames);
    if (pre_r == '0) begin
      if (ppa_r) begin
        post_nxt = post_r - DLY_W'(1);
        if (post_nxt == '0) begin
          plf_nxt = rec_r.frame;
          rl_nxt  = plen(rec_r.frame, pff_r);
        end
      end else begin
        if (lrms_r >= cfg.low_threshold && prev_r < cfg.low_threshold && !inp_r) begin
          inp_nxt = 1'b1;
          lse_nxt = rec_r.frame;
        end else if (lrms_r <= cfg.low_threshold && prev_r > cfg.low_threshold && ins_r) begin
          ins_nxt = 1'b0;
          snd_nxt = snd_r + CNT_W'(1);
          lse_nxt = rec_r.frame;
          if (snd_nxt == cfg.max_sounds) begin
            ppa_nxt = 1'b1;
          end
        end
        if (lrms_r >= cfg.high_threshold && prev_r < cfg.high_threshold &&
            !ins_nxt && inp_nxt) begin
          ins_nxt = 1'b1;
        end
        prev_nxt = lrms_r;
      end
      if (inp_nxt) begin
        diff = rec_r.frame - lse_nxt;
        if (diff > FRAME_W'(cfg.max_gap_frames)) begin
          if (snd_nxt == '0) begin
            hclr     = 1'b1;
            snd_nxt  = '0;
            pff_nxt  = rec_r.frame;
            plf_nxt  = rec_r.frame;
            lse_nxt  = rec_r.frame;
            ins_nxt  = 1'b0;
            inp_nxt  = 1'b0;
            rl_nxt   = '0;
            prev_nxt = '0;
            ppa_nxt  = 1'b0;
            pre_nxt  = DLY_W'(cfg.pad_frames) + DLY_W'(2);
            post_nxt = pps;
          end else if (snd_nxt < cfg.max_sounds && !ppa_nxt) begin
            ppa_nxt = 1'b1;
            if (diff < FRAME_W'(pps)) begin
              post_nxt = DLY_W'(FRAME_W'(pps) - diff);
            end else begin
              post_nxt = '0;
              plf_nxt  = lse_nxt + FRAME_W'(pps);
              rl_nxt   = plen(lse_nxt + FRAME_W'(pps), pff_nxt);
            end
          end
        end
      end else begin
        pff_nxt = pff_r + FRAME_W'(1);
      end
    end else begin
      pre_nxt = pre_r - DLY_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ch_r   <= 1'b0;
      snd_r  <= '0;
      pff_r  <= '0;
      plf_r  <= '0;
      lse_r  <= '0;
      ins_r  <= 1'b0;
      inp_r  <= 1'b0;
      ppa_r  <= 1'b0;
      rl_r   <= '0;
      prev_r <= '0;
      pre_r  <= DLY_W'(7);
      post_r <= DLY_W'(2);
      for (int i = 0; i < HIST_DEPTH; i++) begin
        lh_r[i] <= '0;
        rh_r[i] <= '0;
      end
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!rec_empty) begin
            rec_r  <= rec;
            ch_r   <= 1'b0;
            rrms_r <= '0;
            st_r   <= S_FIR1;
            if (rl_r != '0) begin
              snd_r  <= '0;
              pff_r  <= rec.frame;
              plf_r  <= rec.frame;
              lse_r  <= rec.frame;
              ins_r  <= 1'b0;
              inp_r  <= 1'b0;
              rl_r   <= '0;
              prev_r <= '0;
              ppa_r  <= 1'b0;
              pre_r  <= DLY_W'(cfg.pad_frames) + DLY_W'(2);
              post_r <= post_pad(cfg.pad_frames);
              for (int i = 0; i < HIST_DEPTH; i++) begin
                lh_r[i] <= '0;
                rh_r[i] <= '0;
              end
            end
          end
        end
        S_FIR1: begin
          acc_r <= (FIR_W'(x) << 1) + (FIR_W'(h0) << 2) + (FIR_W'(h1) << 2);
          st_r  <= S_FIR2;
        end
        S_FIR2: begin
          dvd_r <= {fsum, 16'h0};
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          cnt_r <= DCW'(DVD_W);
          for (int i = 1; i < HIST_DEPTH; i++) begin
            if (ch_r) begin
              rh_r[i] <= rh_r[i-1];
            end else begin
              lh_r[i] <= lh_r[i-1];
            end
          end
          if (ch_r) begin
            rh_r[0] <= x;
          end else begin
            lh_r[0] <= x;
          end
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            sx_r   <= ovf_r ? '1 : q_r;
            sres_r <= '0;
            sbit_r <= (ARG_W + 1)'(1) << ARG_W;
            st_r   <= S_SQRT;
          end else begin
            rem_r <= ge ? DW'(rs - (DW + 1)'(dval)) : DW'(rs);
            q_r   <= {q_r[ARG_W-2:0], ge};
            ovf_r <= ovf_r | q_r[ARG_W-1];
            dvd_r <= dvd_r << 1;
            cnt_r <= cnt_r - DCW'(1);
          end
        end
        S_SQRT: begin
          if (sbit_r == '0) begin
            if (ch_r) begin
              rrms_r <= sres_r[RMS_W-1:0];
              st_r   <= S_SM;
            end else begin
              lrms_r <= sres_r[RMS_W-1:0];
              if (cfg.right_enable) begin
                ch_r <= 1'b1;
                st_r <= S_FIR1;
              end else begin
                st_r <= S_SM;
              end
            end
          end else begin
            if ((ARG_W + 2)'(sx_r) >= st_sum) begin
              sx_r   <= ARG_W'((ARG_W + 2)'(sx_r) - st_sum);
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        S_SM: begin
          snd_r  <= snd_nxt;
          pff_r  <= pff_nxt;
          plf_r  <= plf_nxt;
          lse_r  <= lse_nxt;
          ins_r  <= ins_nxt;
          inp_r  <= inp_nxt;
          ppa_r  <= ppa_nxt;
          rl_r   <= rl_nxt;
          prev_r <= prev_nxt;
          pre_r  <= pre_nxt;
          post_r <= post_nxt;
          if (hclr) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
              lh_r[i] <= '0;
              rh_r[i] <= '0;
            end
          end
          st_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!res_full) begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/energy_vad_phrase_detector.sv
// Stereo energy phrase detector. One sample pair is taken per clock while
// full is low; squares are summed per channel in the front end. Each frame end
// hands its sums through a two-frame queue to a back-end sequencer that runs a
// 5-tap smoother, a bit-serial divide and a bit-serial square root per
// channel, then the phrase state machine, and then waits while the output
// queue is full; it takes the next frame end only once its result is pushed.
// Results wait in a two-entry output queue; full rises while the frame queue
// holds two frame ends not yet taken by the back end, and then holds off
// every request, frame end or not.
module energy_vad_phrase_detector import evad_pkg::*; #(
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  parameter int MAX_FRAME_LENGTH = MAX_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  logic                          in_frame_end,
  input  logic [FRAME_W-1:0]            in_frame_number,
  output logic                          empty,
  input  logic                          pop,
  output logic [RMS_W-1:0]              out_left_rms,
  output logic [RMS_W-1:0]              out_right_rms,
  output logic [FRAME_W-1:0]            out_phrase_length,
  output logic [CNT_W-1:0]              out_sound_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  cfg_t       cfg_r;
  frame_rec_t rec_in, rec_out;
  result_t    res_in, res_out;
  logic       rec_push, rec_pop, rec_empty, rec_full;
  logic       res_push, res_full;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign full   = rec_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_length   <= FLEN_W'(160);
      cfg_r.low_threshold  <= RMS_W'(256);
      cfg_r.high_threshold <= RMS_W'(512);
      cfg_r.max_sounds     <= CNT_W'(3);
      cfg_r.max_gap_frames <= GAP_W'(50);
      cfg_r.pad_frames     <= PAD_W'(5);
      cfg_r.right_enable   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_FRAME_LENGTH: cfg_r.frame_length   <= pwdata[FLEN_W-1:0];
        REG_LOW_THR:      cfg_r.low_threshold  <= pwdata[RMS_W-1:0];
        REG_HIGH_THR:     cfg_r.high_threshold <= pwdata[RMS_W-1:0];
        REG_MAX_SOUNDS:   cfg_r.max_sounds     <= pwdata[CNT_W-1:0];
        REG_MAX_GAP:      cfg_r.max_gap_frames <= pwdata[GAP_W-1:0];
        REG_PAD:          cfg_r.pad_frames     <= pwdata[PAD_W-1:0];
        REG_RIGHT_EN:     cfg_r.right_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_LENGTH: prdata = 32'(cfg_r.frame_length);
      REG_LOW_THR:      prdata = 32'(cfg_r.low_threshold);
      REG_HIGH_THR:     prdata = 32'(cfg_r.high_threshold);
      REG_MAX_SOUNDS:   prdata = 32'(cfg_r.max_sounds);
      REG_MAX_GAP:      prdata = 32'(cfg_r.max_gap_frames);
      REG_PAD:          prdata = 32'(cfg_r.pad_frames);
      REG_RIGHT_EN:     prdata = 32'(cfg_r.right_enable);
      default:          prdata = '0;
    endcase
  end

  evad_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (push && !rec_full),
    .left_sample  (in_left_sample),
    .right_sample (in_right_sample),
    .frame_end    (in_frame_end),
    .frame_number (in_frame_number),
    .right_enable (cfg_r.right_enable),
    .rec_push     (rec_push),
    .rec          (rec_in)
  );

  evad_fifo #(.W($bits(frame_rec_t)), .DEPTH(2)) u_recq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (rec_push),
    .wdata (rec_in),
    .full  (rec_full),
    .rd    (rec_pop),
    .rdata (rec_out),
    .empty (rec_empty)
  );

  evad_back #(.MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_empty (rec_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  evad_fifo #(.W($bits(result_t)), .DEPTH(2)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_push),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_left_rms      = res_out.left_rms;
  assign out_right_rms     = res_out.right_rms;
  assign out_phrase_length = res_out.phrase_length;
  assign out_sound_count   = res_out.sound_count;
endmodule
